// ----- hdl/tpdc_pkg.sv -----
// shared types, codes and widths for the two-player delay clock
`default_nettype none
package tpdc_pkg;

    localparam int STAMP_W = 48;
    localparam int TIME_W  = 32;
    // wide enough for stamp + delay + reserve - stamp as a signed value
    localparam int SUM_W   = STAMP_W + 3;

    localparam logic [2:0] KIND_SETTLE = 3'd0;
    localparam logic [2:0] KIND_START  = 3'd1;
    localparam logic [2:0] KIND_PAUSE  = 3'd2;
    localparam logic [2:0] KIND_RESUME = 3'd3;
    localparam logic [2:0] KIND_NEW    = 3'd4;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_FLAG0 = 2'd1;
    localparam logic [1:0] EV_FLAG1 = 2'd2;

    localparam logic [1:0] SIDE_ZERO   = 2'd0;
    localparam logic [1:0] SIDE_ONE    = 2'd1;
    localparam logic [1:0] SIDE_NOBODY = 2'd2;

    localparam logic [1:0] REG_DELAY    = 2'd0;
    localparam logic [1:0] REG_RESERVE0 = 2'd1;
    localparam logic [1:0] REG_RESERVE1 = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic [1:0]         side;
        logic [STAMP_W-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        event_res;
        logic              is_paused;
        logic [1:0]        running_side;
        logic [TIME_W-1:0] delay_remaining;
        logic [TIME_W-1:0] reserve_zero;
        logic [TIME_W-1:0] reserve_one;
        logic              flag_zero;
        logic              flag_one;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] delay_ms;
        logic [TIME_W-1:0] start_reserve_zero;
        logic [TIME_W-1:0] start_reserve_one;
    } cfg_t;

    typedef struct packed {
        logic [STAMP_W-1:0] last_stamp;
        logic               paused;
        logic [1:0]         cur_side;
        logic [TIME_W-1:0]  delay_left;
        logic [TIME_W-1:0]  reserve0;
        logic [TIME_W-1:0]  reserve1;
        logic               flag0;
        logic               flag1;
    } clk_state_t;

endpackage
`default_nettype wire

// ----- hdl/tpdc_cfg.sv -----
// configuration register file: turn delay and the two starting reserves
`default_nettype none
module tpdc_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    output tpdc_pkg::cfg_t    cfg
);
    import tpdc_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DELAY:    cfg_reg.delay_ms           <= cfg_data;
                REG_RESERVE0: cfg_reg.start_reserve_zero <= cfg_data;
                REG_RESERVE1: cfg_reg.start_reserve_one  <= cfg_data;
                default:      ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hdl/tpdc_step.sv -----
// next-state and result logic for one clock event
`default_nettype none
module tpdc_step (
    input  wire tpdc_pkg::cfg_t       cfg,
    input  wire tpdc_pkg::clk_state_t cur,
    input  wire tpdc_pkg::in_item_t   item,
    output tpdc_pkg::clk_state_t      nxt,
    output tpdc_pkg::out_item_t       res
);
    import tpdc_pkg::*;

    logic              later;
    logic              runnable;
    logic              side_bit;
    logic              do_charge;
    logic [TIME_W-1:0] res_sel;
    logic              flag_sel;
    logic [SUM_W-1:0]  delay_diff;
    logic [SUM_W-1:0]  res_diff;
    logic              delay_ok;
    logic              reserve_gt;
    logic [1:0]        ev;

    assign later    = item.now_ms > cur.last_stamp;
    assign runnable = !cur.paused && !cur.cur_side[1];
    assign side_bit = cur.cur_side[0];
    assign res_sel  = side_bit ? cur.reserve1 : cur.reserve0;
    assign flag_sel = side_bit ? cur.flag1 : cur.flag0;

    // last + delay - now: non-negative when the delay covers the elapsed time
    assign delay_diff = {3'b000, cur.last_stamp}
                      + {{(SUM_W-TIME_W){1'b0}}, cur.delay_left}
                      - {3'b000, item.now_ms};
    // last + delay + reserve - now: positive when the reserve outlasts the excess
    assign res_diff = {3'b000, cur.last_stamp}
                    + {{(SUM_W-TIME_W){1'b0}}, cur.delay_left}
                    + {{(SUM_W-TIME_W){1'b0}}, res_sel}
                    - {3'b000, item.now_ms};

    assign delay_ok   = !delay_diff[SUM_W-1];
    assign reserve_gt = !res_diff[SUM_W-1] && (res_diff != '0);

    assign do_charge = (item.kind == KIND_SETTLE) || (item.kind == KIND_START)
                    || ((item.kind == KIND_PAUSE) && !cur.paused);

    always_comb
    begin
        nxt = cur;
        ev  = EV_NONE;

        if (do_charge && later)
        begin
            nxt.last_stamp = item.now_ms;
            if (runnable)
            begin
                if (delay_ok)
                begin
                    nxt.delay_left = delay_diff[TIME_W-1:0];
                end
                else
                begin
                    nxt.delay_left = '0;
                    if (!flag_sel)
                    begin
                        if (reserve_gt)
                        begin
                            if (side_bit) nxt.reserve1 = res_diff[TIME_W-1:0];
                            else          nxt.reserve0 = res_diff[TIME_W-1:0];
                        end
                        else if (side_bit)
                        begin
                            nxt.reserve1 = '0;
                            nxt.flag1    = 1'b1;
                            ev           = EV_FLAG1;
                        end
                        else
                        begin
                            nxt.reserve0 = '0;
                            nxt.flag0    = 1'b1;
                            ev           = EV_FLAG0;
                        end
                    end
                end
            end
        end

        case (item.kind)
            KIND_START:
            begin
                if (!item.side[1])
                begin
                    nxt.cur_side   = item.side;
                    nxt.delay_left = cfg.delay_ms;
                end
                else
                begin
                    nxt.cur_side   = SIDE_NOBODY;
                    nxt.delay_left = '0;
                end
            end
            KIND_PAUSE:
            begin
                nxt.paused = 1'b1;
            end
            KIND_RESUME:
            begin
                if (cur.paused)
                begin
                    nxt.paused = 1'b0;
                    if (later)
                    begin
                        nxt.last_stamp = item.now_ms;
                    end
                end
            end
            KIND_NEW:
            begin
                nxt.last_stamp = '0;
                nxt.paused     = 1'b0;
                nxt.cur_side   = SIDE_NOBODY;
                nxt.delay_left = '0;
                nxt.reserve0   = cfg.start_reserve_zero;
                nxt.reserve1   = cfg.start_reserve_one;
                nxt.flag0      = 1'b0;
                nxt.flag1      = 1'b0;
            end
            default: ;
        endcase
    end

    assign res.event_res       = ev;
    assign res.is_paused       = nxt.paused;
    assign res.running_side    = nxt.cur_side;
    assign res.delay_remaining = nxt.delay_left;
    assign res.reserve_zero    = nxt.reserve0;
    assign res.reserve_one     = nxt.reserve1;
    assign res.flag_zero       = nxt.flag0;
    assign res.flag_one        = nxt.flag1;

endmodule
`default_nettype wire

// ----- hdl/two_player_delay_clock_top.sv -----
// two-player match clock with per-turn delay: top level
// an accepted event waits in the input register and is then offered from the result register
// throughput: one event per cycle while out_stall is low, set by the single-pass
// step logic between the input register and the result and clock state registers
// reset: clock state, configuration and both stages cleared; nobody running
`default_nettype none
module two_player_delay_clock_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire tpdc_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output tpdc_pkg::out_item_t     out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import tpdc_pkg::*;

    cfg_t       cfg;
    clk_state_t state_reg;
    clk_state_t state_next;
    in_item_t   in_item_reg;
    logic       in_valid_reg;
    out_item_t  out_item_reg;
    out_item_t  out_item_next;
    logic       out_valid_reg;
    logic       advance;
    logic       fire;

    tpdc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpdc_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .item (in_item_reg),
        .nxt  (state_next),
        .res  (out_item_next)
    );

    // result register free or being drained this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{cur_side: SIDE_NOBODY, default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // a flag only clears on a new match
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.flag0 && !(fire && in_item_reg.kind == KIND_NEW) |=> state_reg.flag0)
        else $error("flag zero dropped without a new match");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.flag1 && !(fire && in_item_reg.kind == KIND_NEW) |=> state_reg.flag1)
        else $error("flag one dropped without a new match");

    // a flag-one event beat always carries its latched flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.event_res == EV_FLAG1 |-> out_item_reg.flag_one)
        else $error("flag one event without flag one set");

    // input held back only when both stages are full
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cur_side != 2'd3)
        else $error("running side out of range");

endmodule
`default_nettype wire

// ----- test/match_clock_checker.sv -----
// checker for the two-player delay clock: predicts each snapshot and compares it
module match_clock_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  tpdc_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  tpdc_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output int                  mismatches,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import tpdc_pkg::*;

    // configuration copy
    logic [TIME_W-1:0]  delay_setting;
    logic [TIME_W-1:0]  reserve0_setting;
    logic [TIME_W-1:0]  reserve1_setting;

    // predicted clock state
    logic [STAMP_W-1:0] last_stamp;
    logic               paused;
    logic [1:0]         run_side;
    logic [TIME_W-1:0]  delay_left;
    logic [TIME_W-1:0]  reserve_left [2];
    logic               out_of_time [2];

    out_item_t          predicted_snapshots [$];
    out_item_t          oldest_snapshot;
    int                 fail_total = 0;
    int                 pending_total = 0;

    assign mismatches  = fail_total;
    assign outstanding = pending_total;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_total++;
    endtask

    // charge the time since the last stamp to the running side
    function automatic logic [1:0] settle_time(input logic [STAMP_W-1:0] now);
        logic [STAMP_W-1:0] span;
        logic [1:0]         who;
        who = run_side;
        if (now <= last_stamp)
            return EV_NONE;
        span = now - last_stamp;
        last_stamp = now;
        if (paused || who > SIDE_ONE)
            return EV_NONE;
        if ({16'd0, delay_left} >= span)
        begin
            delay_left = delay_left - span[TIME_W-1:0];
            return EV_NONE;
        end
        span = span - {16'd0, delay_left};
        delay_left = '0;
        if (out_of_time[who[0]])
            return EV_NONE;
        if ({16'd0, reserve_left[who[0]]} > span)
        begin
            reserve_left[who[0]] = reserve_left[who[0]] - span[TIME_W-1:0];
            return EV_NONE;
        end
        reserve_left[who[0]] = '0;
        out_of_time[who[0]] = 1'b1;
        return (who == SIDE_ZERO) ? EV_FLAG0 : EV_FLAG1;
    endfunction

    function automatic void start_match();
        last_stamp      = '0;
        paused          = 1'b0;
        run_side        = SIDE_NOBODY;
        delay_left      = '0;
        reserve_left[0] = reserve0_setting;
        reserve_left[1] = reserve1_setting;
        out_of_time[0]  = 1'b0;
        out_of_time[1]  = 1'b0;
    endfunction

    function automatic out_item_t step_clock(input in_item_t ev);
        out_item_t snap;
        logic [1:0] flagged;
        flagged = EV_NONE;
        case (ev.kind)
            KIND_SETTLE: flagged = settle_time(ev.now_ms);
            KIND_START:
            begin
                flagged = settle_time(ev.now_ms);
                if (ev.side <= SIDE_ONE)
                begin
                    run_side   = ev.side;
                    delay_left = delay_setting;
                end
                else
                begin
                    run_side   = SIDE_NOBODY;
                    delay_left = '0;
                end
            end
            KIND_PAUSE:
            begin
                if (!paused)
                begin
                    flagged = settle_time(ev.now_ms);
                    paused  = 1'b1;
                end
            end
            KIND_RESUME:
            begin
                // the gap while paused goes to nobody
                if (paused)
                begin
                    paused = 1'b0;
                    if (ev.now_ms > last_stamp)
                        last_stamp = ev.now_ms;
                end
            end
            KIND_NEW: start_match();
            default: ;
        endcase
        snap.event_res       = flagged;
        snap.is_paused       = paused;
        snap.running_side    = run_side;
        snap.delay_remaining = delay_left;
        snap.reserve_zero    = reserve_left[0];
        snap.reserve_one     = reserve_left[1];
        snap.flag_zero       = out_of_time[0];
        snap.flag_one        = out_of_time[1];
        return snap;
    endfunction

    task automatic compare_snapshot(input out_item_t got, input out_item_t want);
        if (got.event_res !== want.event_res)
            report_mismatch("event_res", 64'(got.event_res), 64'(want.event_res));
        if (got.is_paused !== want.is_paused)
            report_mismatch("is_paused", 64'(got.is_paused), 64'(want.is_paused));
        if (got.running_side !== want.running_side)
            report_mismatch("running_side", 64'(got.running_side),
                            64'(want.running_side));
        if (got.delay_remaining !== want.delay_remaining)
            report_mismatch("delay_remaining", 64'(got.delay_remaining),
                            64'(want.delay_remaining));
        if (got.reserve_zero !== want.reserve_zero)
            report_mismatch("reserve_zero", 64'(got.reserve_zero),
                            64'(want.reserve_zero));
        if (got.reserve_one !== want.reserve_one)
            report_mismatch("reserve_one", 64'(got.reserve_one),
                            64'(want.reserve_one));
        if (got.flag_zero !== want.flag_zero)
            report_mismatch("flag_zero", 64'(got.flag_zero), 64'(want.flag_zero));
        if (got.flag_one !== want.flag_one)
            report_mismatch("flag_one", 64'(got.flag_one), 64'(want.flag_one));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_setting    = '0;
            reserve0_setting = '0;
            reserve1_setting = '0;
            start_match();
            predicted_snapshots.delete();
            pending_total = 0;
        end
        else
        begin
            // results leave before the new beat enters, so a same-edge pair stays in order
            if (out_valid && !out_stall)
            begin
                if (predicted_snapshots.size() == 0)
                    report_mismatch("unexpected result beat", 64'(out_data), 64'd0);
                else
                begin
                    oldest_snapshot = predicted_snapshots.pop_front();
                    compare_snapshot(out_data, oldest_snapshot);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DELAY:    delay_setting    = cfg_data;
                    REG_RESERVE0: reserve0_setting = cfg_data;
                    REG_RESERVE1: reserve1_setting = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predicted_snapshots.push_back(step_clock(in_data));
            pending_total = predicted_snapshots.size();
        end
    end

endmodule

// ----- test/two_player_delay_clock_top_tb.sv -----
// testbench top for the two-player delay clock: stimulus, idling and verdict
module two_player_delay_clock_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tpdc_pkg::*;

    localparam int         RUN_LIMIT       = 200000;
    localparam int         PHASE_ITEMS     = 100;
    localparam logic [2:0] KIND_UNUSED_LO  = KIND_NEW + 3'd1;
    localparam logic [2:0] KIND_UNUSED_HI  = 3'd7;
    localparam logic [1:0] SIDE_NOBODY_ALT = 2'd3;
    localparam logic [1:0] REG_UNUSED      = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_stall;
    out_item_t          out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    int                 mismatch_count;
    int                 pending_count;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int                 cycle_count = 0;
    logic [STAMP_W-1:0] stamp_now;

    two_player_delay_clock_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    match_clock_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatch_count),
        .outstanding (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver back-pressure
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // tasks are entered and left just after a falling edge
    task automatic send_event(input logic [2:0] kind, input logic [1:0] side,
                              input logic [STAMP_W-1:0] now);
        in_item_t beat;
        beat.kind   = kind;
        beat.side   = side;
        beat.now_ms = now;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = beat;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic setup_match(input logic [31:0] delay, input logic [31:0] res0,
                               input logic [31:0] res1);
        write_reg(REG_DELAY, delay);
        write_reg(REG_RESERVE0, res0);
        write_reg(REG_RESERVE1, res1);
        send_event(KIND_NEW, 2'($urandom_range(SIDE_NOBODY_ALT, SIDE_ZERO)),
                   48'({$urandom(), $urandom()}));
        stamp_now = 48'($urandom_range(50));
    endtask

    task automatic random_event();
        logic [2:0]         kind;
        logic [1:0]         side;
        logic [STAMP_W-1:0] stamp;
        logic [63:0]        wide;
        int                 roll;
        roll = $urandom_range(99);
        if (roll < 23)
            kind = KIND_START;
        else if (roll < 34)
            kind = KIND_PAUSE;
        else if (roll < 45)
            kind = KIND_RESUME;
        else if (roll < 51)
            kind = KIND_NEW;
        else if (roll < 55)
            kind = 3'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
        else
            kind = KIND_SETTLE;
        if ($urandom_range(99) < 80)
            side = 2'($urandom_range(SIDE_ONE, SIDE_ZERO));
        else
            side = 2'($urandom_range(SIDE_NOBODY_ALT, SIDE_NOBODY));
        // mostly small forward steps so reserves drain over a match
        roll = $urandom_range(99);
        if (roll < 10)
            stamp_now = stamp_now;
        else if (roll < 60)
            stamp_now = stamp_now + 48'($urandom_range(80));
        else if (roll < 85)
            stamp_now = stamp_now + 48'($urandom_range(2000));
        else if (roll < 92)
            stamp_now = stamp_now + 48'($urandom());
        else if (roll < 95)
        begin
            wide      = {$urandom(), $urandom()};
            stamp_now = wide[STAMP_W-1:0];
        end
        if (roll < 95)
            stamp = stamp_now;
        else
            stamp = stamp_now - 48'($urandom_range(300, 1));
        send_event(kind, side, stamp);
        if (kind == KIND_NEW)
            stamp_now = 48'($urandom_range(50));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_DELAY;
        cfg_data  = '0;
        stamp_now = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // out of reset: zero delay and zero reserve flag on the first charge
        send_event(KIND_SETTLE, SIDE_ZERO, 48'd5);
        send_event(KIND_START, SIDE_ZERO, 48'd7);
        send_event(KIND_SETTLE, SIDE_ZERO, 48'd9);
        drain();
        write_reg(REG_DELAY, 32'd5);
        write_reg(REG_RESERVE0, 32'd100);
        write_reg(REG_RESERVE1, 32'd45);
        // new match ignores its stamp
        send_event(KIND_NEW, SIDE_NOBODY_ALT, '1);
        send_event(KIND_SETTLE, SIDE_ZERO, 48'd10);
        send_event(KIND_START, SIDE_ZERO, 48'd20);
        send_event(KIND_SETTLE, SIDE_ONE, 48'd23);
        send_event(KIND_SETTLE, SIDE_ZERO, 48'd23);
        send_event(KIND_SETTLE, SIDE_ZERO, 48'd15);
        send_event(KIND_SETTLE, SIDE_ZERO, 48'd40);
        send_event(KIND_PAUSE, SIDE_ONE, 48'd50);
        send_event(KIND_PAUSE, SIDE_ZERO, 48'd60);
        send_event(KIND_SETTLE, SIDE_ZERO, 48'd70);
        send_event(KIND_START, SIDE_ONE, 48'd80);
        send_event(KIND_RESUME, SIDE_ZERO, 48'd90);
        send_event(KIND_RESUME, SIDE_ZERO, 48'd95);
        send_event(KIND_SETTLE, SIDE_ZERO, 48'd100);
        // reserve short of the excess flags side one
        send_event(KIND_SETTLE, SIDE_ZERO, 48'd145);
        send_event(KIND_SETTLE, SIDE_ZERO, 48'd300);
        send_event(KIND_START, SIDE_NOBODY_ALT, 48'd310);
        send_event(KIND_START, SIDE_NOBODY, 48'd320);
        send_event(KIND_START, SIDE_ZERO, 48'd330);
        send_event(KIND_SETTLE, SIDE_ZERO, '1);
        send_event(KIND_UNUSED_LO, SIDE_NOBODY_ALT, '1);
        send_event(KIND_UNUSED_HI, SIDE_NOBODY_ALT, '1);
        send_event(KIND_NEW, SIDE_ZERO, '0);
        send_event(KIND_PAUSE, SIDE_NOBODY_ALT, '0);

        for (int phase = 0; phase < 5; phase++)
        begin
            drain();
            idle_pct  = 0;
            stall_pct = 0;
            case (phase)
                0: setup_match('0, '0, '0);
                1: setup_match(32'd20, 32'd500, 32'd800);
                2: setup_match('1, '1, '1);
                3: setup_match($urandom_range(300), $urandom_range(3000), $urandom_range(3000));
                default:
                begin
                    write_reg(REG_UNUSED, $urandom());
                    setup_match($urandom(), $urandom(), $urandom());
                end
            endcase
            case (phase)
                1: idle_pct = 52;
                2: stall_pct = 52;
                3:
                begin
                    idle_pct  = 6;
                    stall_pct = 6;
                end
                4:
                begin
                    idle_pct  = 52;
                    stall_pct = 52;
                end
                default: ;
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                random_event();
                // hold off until the block has emptied once
                if (phase == 1 && i == PHASE_ITEMS / 2)
                    drain();
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
